// File: src/b64sc_pkg.sv
// ----------------------------------------------------------------------------
// Base64 codec package
// Shared types, constants and symbol mapping functions for the base64 codec.
// ----------------------------------------------------------------------------
package b64sc_pkg;

    localparam logic [7:0] PAD_CHAR = 8'h3D;
    localparam int MAX_RESULTS = 4;
    localparam int CNT_W = 3;

    typedef struct packed {
        logic [7:0] data;
        logic       byte_valid;
        logic       last;
        logic       bad;
    } t_result;

    typedef struct packed {
        logic [1:0] phase;
        logic [5:0] left;
        logic       pad;
    } t_state;

    typedef struct packed {
        t_result [MAX_RESULTS-1:0] res;
        logic [CNT_W-1:0]          count;
    } t_step;

    function automatic logic [7:0] enc_char(input logic [5:0] v);
        logic [7:0] c;
        if (v < 6'd26) begin
            c = 8'h41 + {2'b00, v};
        end else if (v < 6'd52) begin
            c = 8'h61 + {2'b00, v} - 8'd26;
        end else if (v < 6'd62) begin
            c = 8'h30 + {2'b00, v} - 8'd52;
        end else if (v == 6'd62) begin
            c = 8'h2B;
        end else begin
            c = 8'h2F;
        end
        return c;
    endfunction

    // Returns the bad flag in bit 6 and the symbol value in bits 5:0.
    function automatic logic [6:0] dec_sym(input logic [7:0] c);
        logic [7:0] t;
        logic [6:0] r;
        t = 8'h00;
        if (c >= 8'h41 && c <= 8'h5A) begin
            t = c - 8'h41;
            r = {1'b0, t[5:0]};
        end else if (c >= 8'h61 && c <= 8'h7A) begin
            t = c - 8'h61 + 8'd26;
            r = {1'b0, t[5:0]};
        end else if (c >= 8'h30 && c <= 8'h39) begin
            t = c - 8'h30 + 8'd52;
            r = {1'b0, t[5:0]};
        end else if (c == 8'h2B) begin
            r = {1'b0, 6'd62};
        end else if (c == 8'h2F) begin
            r = {1'b0, 6'd63};
        end else begin
            r = {1'b1, t[5:0]};
        end
        return r;
    endfunction

endpackage

// File: src/b64sc_step.sv
// ----------------------------------------------------------------------------
// Base64 codec step logic
// Computes the results and next group state for one registered input item.
// ----------------------------------------------------------------------------
module b64sc_step (
    input  logic              i_mode,
    input  logic [7:0]        i_data,
    input  logic              i_last,
    input  b64sc_pkg::t_state i_state,
    output b64sc_pkg::t_state o_state,
    output b64sc_pkg::t_step  o_step
);

    b64sc_pkg::t_result [b64sc_pkg::MAX_RESULTS-1:0] w_res;
    logic [b64sc_pkg::CNT_W-1:0] w_cnt;
    b64sc_pkg::t_state w_st;
    logic [6:0] w_sym;

    function automatic b64sc_pkg::t_result mk(input logic [7:0] d, input logic v,
                                              input logic b);
        b64sc_pkg::t_result r;
        r.data       = d;
        r.byte_valid = v;
        r.last       = 1'b0;
        r.bad        = b;
        return r;
    endfunction

    always_comb begin
        w_res = '0;
        w_cnt = '0;
        w_st  = i_state;
        w_sym = b64sc_pkg::dec_sym(i_data);
        if (!i_mode) begin
            unique case (i_state.phase)
                2'd0: begin
                    w_res[0] = mk(b64sc_pkg::enc_char(i_data[7:2]), 1'b1, 1'b0);
                    w_st.left = {4'b0, i_data[1:0]};
                    w_st.phase = 2'd1;
                    w_cnt = 3'd1;
                end
                2'd1: begin
                    w_res[0] = mk(b64sc_pkg::enc_char({i_state.left[1:0], i_data[7:4]}),
                                  1'b1, 1'b0);
                    w_st.left = {2'b0, i_data[3:0]};
                    w_st.phase = 2'd2;
                    w_cnt = 3'd1;
                end
                default: begin
                    w_res[0] = mk(b64sc_pkg::enc_char({i_state.left[3:0], i_data[7:6]}),
                                  1'b1, 1'b0);
                    w_res[1] = mk(b64sc_pkg::enc_char(i_data[5:0]), 1'b1, 1'b0);
                    w_st.left = '0;
                    w_st.phase = 2'd0;
                    w_cnt = 3'd2;
                end
            endcase
            if (i_last) begin
                unique case (w_st.phase)
                    2'd1: begin
                        w_res[1] = mk(b64sc_pkg::enc_char({w_st.left[1:0], 4'b0}),
                                      1'b1, 1'b0);
                        w_res[2] = mk(b64sc_pkg::PAD_CHAR, 1'b1, 1'b0);
                        w_res[3] = mk(b64sc_pkg::PAD_CHAR, 1'b1, 1'b0);
                        w_res[3].last = 1'b1;
                        w_cnt = 3'd4;
                    end
                    2'd2: begin
                        w_res[1] = mk(b64sc_pkg::enc_char({w_st.left[3:0], 2'b0}),
                                      1'b1, 1'b0);
                        w_res[2] = mk(b64sc_pkg::PAD_CHAR, 1'b1, 1'b0);
                        w_res[2].last = 1'b1;
                        w_cnt = 3'd3;
                    end
                    default: begin
                        w_res[1].last = 1'b1;
                    end
                endcase
                w_st = '0;
            end
        end else begin
            if (!i_state.pad) begin
                if (i_data == b64sc_pkg::PAD_CHAR) begin
                    w_st.pad  = 1'b1;
                    w_st.left = '0;
                end else if (w_sym[6]) begin
                    w_res[0] = mk(8'h00, 1'b0, 1'b1);
                    w_cnt = 3'd1;
                end else begin
                    unique case (i_state.phase)
                        2'd0: begin
                            w_st.left = w_sym[5:0];
                            w_st.phase = 2'd1;
                        end
                        2'd1: begin
                            w_res[0] = mk({i_state.left, w_sym[5:4]}, 1'b1, 1'b0);
                            w_st.left = {2'b0, w_sym[3:0]};
                            w_st.phase = 2'd2;
                            w_cnt = 3'd1;
                        end
                        2'd2: begin
                            w_res[0] = mk({i_state.left[3:0], w_sym[5:2]}, 1'b1, 1'b0);
                            w_st.left = {4'b0, w_sym[1:0]};
                            w_st.phase = 2'd3;
                            w_cnt = 3'd1;
                        end
                        default: begin
                            w_res[0] = mk({i_state.left[1:0], w_sym[5:0]}, 1'b1, 1'b0);
                            w_st.left = '0;
                            w_st.phase = 2'd0;
                            w_cnt = 3'd1;
                        end
                    endcase
                end
            end
            if (i_last) begin
                w_cnt = 3'd1;
                w_res[0].last = 1'b1;
                w_st = '0;
            end
        end
    end

    assign o_state      = w_st;
    assign o_step.res   = w_res;
    assign o_step.count = w_cnt;

endmodule

// File: src/b64sc_out_buf.sv
// ----------------------------------------------------------------------------
// Base64 codec result buffer
// Holds the results of one item and hands them out one per transaction.
// ----------------------------------------------------------------------------
module b64sc_out_buf (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_load,
    input  b64sc_pkg::t_step   i_step,
    input  logic               i_ready,
    output logic               o_valid,
    output logic               o_free,
    output b64sc_pkg::t_result o_res
);

    b64sc_pkg::t_result [b64sc_pkg::MAX_RESULTS-1:0] r_res;
    logic [b64sc_pkg::CNT_W-1:0] r_rem;
    logic [1:0] r_idx;

    assign o_valid = (r_rem != '0);
    assign o_free  = (r_rem == '0) || (r_rem == 3'd1 && i_ready);
    assign o_res   = r_res[r_idx];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem <= '0;
            r_idx <= '0;
        end else if (i_load) begin
            r_rem <= i_step.count;
            r_idx <= '0;
        end else if (o_valid && i_ready) begin
            r_rem <= r_rem - 3'd1;
            r_idx <= r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_res <= i_step.res;
        end
    end

endmodule

// File: src/base64_stream_codec.sv
// ----------------------------------------------------------------------------
// Base64 stream codec
// Streaming base64 encoder and decoder with the standard alphabet.
// ----------------------------------------------------------------------------
// Input items arrive on i_valid/o_ready: a raw byte when encoding, an ASCII
// character when decoding, with i_last_in on the final item of a message.
// Results leave on o_valid/i_ready, one per transaction, with o_last_out on
// the final result of a message and o_bad_symbol on a rejected character.
// The mode register is written on i_cfg_valid/o_cfg_ready; the user must
// write it only while the block is idle, which the block does not enforce.
// A write also clears the group state. An accepted item is held in the input
// register, then its results are computed in one pass and loaded into the
// result buffer once it is free, which presents the first of them on o_valid.
// The result buffer hands out one result per cycle while the receiver is
// ready; an item has one or two results per encoded byte, up to four on the
// last byte, and one or none per decoded character. The input register
// accepts a new item while the buffer drains.
// Reset clears the mode to encode, the group state and both stages.
// When the receiver stalls, the buffer holds its result, the input register
// fills and o_ready drops until the buffer frees.
// ----------------------------------------------------------------------------
module base64_stream_codec (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [7:0] i_data_in,
    input  logic       i_last_in,
    output logic       o_valid,
    input  logic       i_ready,
    output logic [7:0] o_data_out,
    output logic       o_byte_valid,
    output logic       o_last_out,
    output logic       o_bad_symbol,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic       i_decode_mode
);

    logic              r_in_valid;
    logic [7:0]        r_in_data;
    logic              r_in_last;
    logic              r_mode;
    b64sc_pkg::t_state r_state;
    b64sc_pkg::t_state n_state;
    b64sc_pkg::t_step  w_step;
    b64sc_pkg::t_result w_res;
    logic              w_free;
    logic              w_load;

    assign w_load      = r_in_valid && w_free;
    assign o_ready     = !r_in_valid || w_free;
    assign o_cfg_ready = 1'b1;

    b64sc_step u_step (
        .i_mode  (r_mode),
        .i_data  (r_in_data),
        .i_last  (r_in_last),
        .i_state (r_state),
        .o_state (n_state),
        .o_step  (w_step)
    );

    b64sc_out_buf u_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (w_load),
        .i_step  (w_step),
        .i_ready (i_ready),
        .o_valid (o_valid),
        .o_free  (w_free),
        .o_res   (w_res)
    );

    assign o_data_out   = w_res.data;
    assign o_byte_valid = w_res.byte_valid;
    assign o_last_out   = w_res.last;
    assign o_bad_symbol = w_res.bad;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_mode     <= 1'b0;
            r_state    <= '0;
        end else begin
            if (i_valid && o_ready) begin
                r_in_valid <= 1'b1;
            end else if (w_load) begin
                r_in_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_mode  <= i_decode_mode;
                r_state <= '0;
            end else if (w_load) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_in_data <= i_data_in;
            r_in_last <= i_last_in;
        end
    end

endmodule

// File: src/b64sc_checker.sv
// ----------------------------------------------------------------------------
// Base64 codec checker
// Port level assertions for the base64 codec, bound to the top level.
// ----------------------------------------------------------------------------
module b64sc_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       o_valid,
    input logic       i_ready,
    input logic [7:0] o_data_out,
    input logic       o_byte_valid,
    input logic       o_last_out,
    input logic       o_bad_symbol
);

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_data_out) && $stable(o_last_out))
        else $error("Stalled result transaction changed.");

    a_bad_no_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_bad_symbol |-> !o_byte_valid && o_data_out == 8'h00)
        else $error("Bad symbol result carries data.");

    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_byte_valid && !o_bad_symbol |-> o_last_out && o_data_out == 8'h00)
        else $error("Empty result is not an end marker.");

    a_reset_idle: assert property (@(posedge i_clk)
        $past(!i_rst_n) |-> !o_valid)
        else $error("Result valid right after reset.");

endmodule

bind base64_stream_codec b64sc_checker u_b64sc_checker (.*);
